/* hdl/cssu_pkg.sv */
// Package for the compressor start/stop sequencer: payload structs, phase codes,
// register indexes and register reset values. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cssu_pkg;

   localparam int CsrAddrWidth = 5;
   localparam int CsrDataWidth = 32;

   typedef enum logic [2:0] {
      REG_PRESS_TICKS       = 3'd0,
      REG_START_WAIT_TICKS  = 3'd1,
      REG_STOP_WAIT_TICKS   = 3'd2,
      REG_START_RETRY_LIMIT = 3'd3,
      REG_STOP_RETRY_LIMIT  = 3'd4,
      REG_VALVE_DRIVE_LEVEL = 3'd5
   } reg_index_type;

   localparam logic [15:0] PressTicksReset     = 16'd40;
   localparam logic [15:0] StartWaitTicksReset = 16'd100;
   localparam logic [15:0] StopWaitTicksReset  = 16'd6000;
   localparam logic [3:0]  StartRetryReset     = 4'd4;
   localparam logic [3:0]  StopRetryReset      = 4'd3;
   localparam logic [7:0]  ValveDriveReset     = 8'd150;

   typedef enum logic [3:0] {
      PHASE_OFF           = 4'd0,
      PHASE_ENERGIZED     = 4'd1,
      PHASE_PRESS_START   = 4'd2,
      PHASE_RELEASE_START = 4'd3,
      PHASE_DRYER_ON      = 4'd4,
      PHASE_WAIT_RELIEF   = 4'd5,
      PHASE_OPEN_VALVE    = 4'd6,
      PHASE_RUNNING       = 4'd7,
      PHASE_PRESS_STOP    = 4'd8,
      PHASE_RELEASE_STOP  = 4'd9,
      PHASE_CLOSE_VALVE   = 4'd10,
      PHASE_WAIT_STOPPED  = 4'd11,
      PHASE_STOP_FAULT    = 4'd12,
      PHASE_START_FAULT   = 4'd13
   } phase_type;

   typedef struct packed {
      logic powered;
      logic running;
      logic relief;
      logic closed_switch;
      logic open_switch;
      logic start_pulse;
      logic stop_pulse;
   } req_payload_type;

   typedef struct packed {
      logic [3:0] phase_code;
      logic       start_relay;
      logic       stop_relay;
      logic [7:0] motor_line_a;
      logic [7:0] motor_line_b;
      logic       valve_is_open;
      logic [7:0] user_total;
   } rsp_payload_type;

endpackage
`default_nettype wire

/* hdl/compressor_start_stop_sequencer_unit.sv */
// Top level of the compressor start/stop sequencer: input register, phase logic,
// result register and APB-style register file. Depends on cssu_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Each transaction is one tick of status inputs and yields exactly one result. The block
// takes one transaction per clock while results are taken. An accepted transaction is held in
// the input register; the phase logic then updates the sequencer state and loads the result
// register, a step that waits while a result is not yet taken. The input register lets
// a new transaction enter while a result still waits to be taken. The user must write
// registers only while the block is idle; the block itself does not enforce this.
module compressor_start_stop_sequencer_unit
   import cssu_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire req_payload_type         req_payload,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output rsp_payload_type              rsp_payload,
   input  wire logic                    psel,
   input  wire logic                    penable,
   input  wire logic                    pwrite,
   input  wire logic [CsrAddrWidth-1:0] paddr,
   input  wire logic [CsrDataWidth-1:0] pwdata,
   output logic [CsrDataWidth-1:0]      prdata,
   output logic                         pready
);

   logic [15:0] press_ticks_ff;
   logic [15:0] start_wait_ff;
   logic [15:0] stop_wait_ff;
   logic [3:0]  start_limit_ff;
   logic [3:0]  stop_limit_ff;
   logic [7:0]  drive_level_ff;

   logic            in_valid_ff;
   req_payload_type in_data_ff;
   logic            out_valid_ff;
   rsp_payload_type out_data_ff;
   rsp_payload_type out_data_in;
   logic            out_free;
   logic            advance;

   phase_type   phase_ff, phase_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [3:0]  retries_ff, retries_in;
   logic [7:0]  users_ff, users_in;
   logic        pending_ff, pending_in;
   logic        valve_open_ff, valve_open_in;
   logic        start_relay_ff, start_relay_in;
   logic        stop_relay_ff, stop_relay_in;
   logic [7:0]  line_a_ff, line_a_in;
   logic [7:0]  line_b_ff, line_b_in;

   reg_index_type csr_index;
   logic          csr_write;

   assign pready    = 1'b1;
   assign csr_index = reg_index_type'(paddr[CsrAddrWidth-1:2]);
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         press_ticks_ff <= PressTicksReset;
         start_wait_ff  <= StartWaitTicksReset;
         stop_wait_ff   <= StopWaitTicksReset;
         start_limit_ff <= StartRetryReset;
         stop_limit_ff  <= StopRetryReset;
         drive_level_ff <= ValveDriveReset;
      end else if (csr_write) begin
         case (csr_index)
            REG_PRESS_TICKS:       press_ticks_ff <= pwdata[15:0];
            REG_START_WAIT_TICKS:  start_wait_ff  <= pwdata[15:0];
            REG_STOP_WAIT_TICKS:   stop_wait_ff   <= pwdata[15:0];
            REG_START_RETRY_LIMIT: start_limit_ff <= pwdata[3:0];
            REG_STOP_RETRY_LIMIT:  stop_limit_ff  <= pwdata[3:0];
            REG_VALVE_DRIVE_LEVEL: drive_level_ff <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_PRESS_TICKS:       prdata = {16'd0, press_ticks_ff};
         REG_START_WAIT_TICKS:  prdata = {16'd0, start_wait_ff};
         REG_STOP_WAIT_TICKS:   prdata = {16'd0, stop_wait_ff};
         REG_START_RETRY_LIMIT: prdata = {28'd0, start_limit_ff};
         REG_STOP_RETRY_LIMIT:  prdata = {28'd0, stop_limit_ff};
         REG_VALVE_DRIVE_LEVEL: prdata = {24'd0, drive_level_ff};
         default:               prdata = '0;
      endcase
   end

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign rsp_valid = out_valid_ff;
   assign rsp_payload = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_payload;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PHASE_OFF;
         elapsed_ff     <= '0;
         retries_ff     <= '0;
         users_ff       <= '0;
         pending_ff     <= 1'b0;
         valve_open_ff  <= 1'b0;
         start_relay_ff <= 1'b0;
         stop_relay_ff  <= 1'b0;
         line_a_ff      <= '0;
         line_b_ff      <= '0;
      end else if (advance) begin
         phase_ff       <= phase_in;
         elapsed_ff     <= elapsed_in;
         retries_ff     <= retries_in;
         users_ff       <= users_in;
         pending_ff     <= pending_in;
         valve_open_ff  <= valve_open_in;
         start_relay_ff <= start_relay_in;
         stop_relay_ff  <= stop_relay_in;
         line_a_ff      <= line_a_in;
         line_b_ff      <= line_b_in;
      end
   end

   always_comb begin
      logic [15:0] tick;
      logic [7:0]  joined;
      tick           = (elapsed_ff == 16'hFFFF) ? elapsed_ff : elapsed_ff + 16'd1;
      phase_in       = phase_ff;
      elapsed_in     = tick;
      retries_in     = retries_ff;
      users_in       = users_ff;
      pending_in     = pending_ff || (in_data_ff.start_pulse && phase_ff != PHASE_RUNNING);
      valve_open_in  = valve_open_ff;
      start_relay_in = start_relay_ff;
      stop_relay_in  = stop_relay_ff;
      line_a_in      = line_a_ff;
      line_b_in      = line_b_ff;
      joined         = users_ff;

      case (phase_ff)
         PHASE_OFF, PHASE_CLOSE_VALVE: begin
            if (in_data_ff.closed_switch) begin
               line_a_in = drive_level_ff;
               line_b_in = '0;
            end else begin
               line_a_in     = '0;
               line_b_in     = '0;
               valve_open_in = 1'b0;
            end
            if (phase_ff == PHASE_OFF) begin
               if (!valve_open_in && in_data_ff.powered) begin
                  phase_in = PHASE_ENERGIZED;
               end
            end else if (!valve_open_in) begin
               phase_in = PHASE_WAIT_STOPPED;
            end
         end
         PHASE_ENERGIZED: begin
            retries_in = '0;
            if (pending_in) begin
               phase_in = PHASE_PRESS_START;
            end
         end
         PHASE_PRESS_START: begin
            pending_in     = 1'b0;
            start_relay_in = 1'b1;
            if (tick >= press_ticks_ff) begin
               phase_in = PHASE_RELEASE_START;
            end
         end
         PHASE_RELEASE_START: begin
            start_relay_in = 1'b0;
            if (in_data_ff.running) begin
               retries_in = '0;
               users_in   = 8'd1;
               phase_in   = PHASE_DRYER_ON;
            end else if (tick >= start_wait_ff) begin
               if (retries_ff < start_limit_ff) begin
                  retries_in = retries_ff + 4'd1;
                  phase_in   = PHASE_PRESS_START;
               end else begin
                  phase_in = PHASE_START_FAULT;
               end
            end
         end
         PHASE_DRYER_ON: begin
            phase_in = PHASE_WAIT_RELIEF;
         end
         PHASE_WAIT_RELIEF: begin
            if (in_data_ff.relief) begin
               phase_in = PHASE_OPEN_VALVE;
            end
         end
         PHASE_OPEN_VALVE: begin
            if (in_data_ff.open_switch) begin
               line_a_in = '0;
               line_b_in = drive_level_ff;
            end else begin
               line_a_in     = '0;
               line_b_in     = '0;
               valve_open_in = 1'b1;
            end
            if (valve_open_in) begin
               phase_in = PHASE_RUNNING;
            end
         end
         PHASE_RUNNING: begin
            if (in_data_ff.start_pulse && users_ff != 8'hFF) begin
               joined = users_ff + 8'd1;
            end
            users_in = joined;
            if (in_data_ff.stop_pulse && joined != 8'd0) begin
               users_in = joined - 8'd1;
            end
            if (users_in == 8'd0) begin
               phase_in = PHASE_PRESS_STOP;
            end
         end
         PHASE_PRESS_STOP: begin
            pending_in    = 1'b0;
            stop_relay_in = 1'b1;
            if (tick >= press_ticks_ff) begin
               phase_in = PHASE_RELEASE_STOP;
            end
         end
         PHASE_RELEASE_STOP: begin
            stop_relay_in = 1'b0;
            phase_in      = PHASE_CLOSE_VALVE;
         end
         PHASE_WAIT_STOPPED: begin
            if (!in_data_ff.running) begin
               retries_in = '0;
               phase_in   = PHASE_ENERGIZED;
            end else if (tick >= stop_wait_ff) begin
               if (retries_ff < stop_limit_ff) begin
                  retries_in = retries_ff + 4'd1;
                  phase_in   = PHASE_PRESS_STOP;
               end else begin
                  phase_in = PHASE_STOP_FAULT;
               end
            end
         end
         default: ;
      endcase

      if (phase_in != phase_ff) begin
         elapsed_in = '0;
      end

      out_data_in.phase_code    = phase_in;
      out_data_in.start_relay   = start_relay_in;
      out_data_in.stop_relay    = stop_relay_in;
      out_data_in.motor_line_a  = line_a_in;
      out_data_in.motor_line_b  = line_b_in;
      out_data_in.valve_is_open = valve_open_in;
      out_data_in.user_total    = users_in;
   end

   motor_lines_exclusive: assert property (@(posedge clock) disable iff (reset)
      line_a_ff == 8'd0 || line_b_ff == 8'd0)
      else $error("Both valve motor lines are driven.");

   relays_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(start_relay_ff && stop_relay_ff))
      else $error("Start and stop relays are pressed together.");

   running_has_users: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PHASE_RUNNING |-> users_ff != 8'd0)
      else $error("Running phase with no users.");

   fault_holds: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PHASE_STOP_FAULT || phase_ff == PHASE_START_FAULT) |=>
      phase_ff == $past(phase_ff))
      else $error("A fault phase was left without reset.");

   result_follows_advance: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid && rsp_payload.phase_code == phase_ff)
      else $error("Result register does not match the sequencer phase.");

endmodule
`default_nettype wire
